@@ hw/rtl/ptrr_pkg.sv @@
package ptrr_pkg;

  // Fraction bits of a point coordinate; translate offsets are whole numbers.
  localparam int FRAC_BITS = 16;

  // Fraction bits of the sine and cosine values (65536 = 1.0).
  localparam int TRIG_BITS = 16;

  localparam int COORD_W = 32;
  localparam int OFFS_W  = 16;
  localparam int ANGLE_W = 16;
  localparam int TRIG_W  = TRIG_BITS + 2;
  localparam int PROD_W  = COORD_W + TRIG_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int TRANS_W = ((OFFS_W + FRAC_BITS > COORD_W) ?
                            (OFFS_W + FRAC_BITS) : COORD_W) + 1;
  localparam int SAT_W   = 52;

  typedef enum logic [1:0] {
    FUNC_TRANSLATE = 2'd0,
    FUNC_REFLECT   = 2'd1,
    FUNC_ROTATE    = 2'd2,
    FUNC_PASS      = 2'd3
  } func_t;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  typedef struct packed {
    coord_t value;
    logic   clipped;
  } sat_res_t;

  // Clip a wide signed value to the signed coordinate range.
  function automatic sat_res_t sat_coord(input logic signed [SAT_W-1:0] v);
    sat_res_t res;
    logic     ovf;
    ovf = (v[SAT_W-1:COORD_W-1] != {(SAT_W-COORD_W+1){1'b0}}) &&
          (v[SAT_W-1:COORD_W-1] != {(SAT_W-COORD_W+1){1'b1}});
    res.clipped = ovf;
    if (ovf) begin
      res.value = v[SAT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      res.value = v[COORD_W-1:0];
    end
    return res;
  endfunction

  // Quarter-wave sine, round(65536 * sin(k degrees)) for k = 0..90.
  function automatic logic [TRIG_BITS:0] sin_quarter(input logic [6:0] k);
    logic [TRIG_BITS:0] v;
    case (k)
      7'd0:  v = 17'd0;      7'd1:  v = 17'd1144;   7'd2:  v = 17'd2287;
      7'd3:  v = 17'd3430;   7'd4:  v = 17'd4572;   7'd5:  v = 17'd5712;
      7'd6:  v = 17'd6850;   7'd7:  v = 17'd7987;   7'd8:  v = 17'd9121;
      7'd9:  v = 17'd10252;  7'd10: v = 17'd11380;  7'd11: v = 17'd12505;
      7'd12: v = 17'd13626;  7'd13: v = 17'd14742;  7'd14: v = 17'd15855;
      7'd15: v = 17'd16962;  7'd16: v = 17'd18064;  7'd17: v = 17'd19161;
      7'd18: v = 17'd20252;  7'd19: v = 17'd21336;  7'd20: v = 17'd22415;
      7'd21: v = 17'd23486;  7'd22: v = 17'd24550;  7'd23: v = 17'd25607;
      7'd24: v = 17'd26656;  7'd25: v = 17'd27697;  7'd26: v = 17'd28729;
      7'd27: v = 17'd29753;  7'd28: v = 17'd30767;  7'd29: v = 17'd31772;
      7'd30: v = 17'd32768;  7'd31: v = 17'd33754;  7'd32: v = 17'd34729;
      7'd33: v = 17'd35693;  7'd34: v = 17'd36647;  7'd35: v = 17'd37590;
      7'd36: v = 17'd38521;  7'd37: v = 17'd39441;  7'd38: v = 17'd40348;
      7'd39: v = 17'd41243;  7'd40: v = 17'd42126;  7'd41: v = 17'd42995;
      7'd42: v = 17'd43852;  7'd43: v = 17'd44695;  7'd44: v = 17'd45525;
      7'd45: v = 17'd46341;  7'd46: v = 17'd47143;  7'd47: v = 17'd47930;
      7'd48: v = 17'd48703;  7'd49: v = 17'd49461;  7'd50: v = 17'd50203;
      7'd51: v = 17'd50931;  7'd52: v = 17'd51643;  7'd53: v = 17'd52339;
      7'd54: v = 17'd53020;  7'd55: v = 17'd53684;  7'd56: v = 17'd54332;
      7'd57: v = 17'd54963;  7'd58: v = 17'd55578;  7'd59: v = 17'd56175;
      7'd60: v = 17'd56756;  7'd61: v = 17'd57319;  7'd62: v = 17'd57865;
      7'd63: v = 17'd58393;  7'd64: v = 17'd58903;  7'd65: v = 17'd59396;
      7'd66: v = 17'd59870;  7'd67: v = 17'd60326;  7'd68: v = 17'd60764;
      7'd69: v = 17'd61183;  7'd70: v = 17'd61584;  7'd71: v = 17'd61966;
      7'd72: v = 17'd62328;  7'd73: v = 17'd62672;  7'd74: v = 17'd62997;
      7'd75: v = 17'd63303;  7'd76: v = 17'd63589;  7'd77: v = 17'd63856;
      7'd78: v = 17'd64104;  7'd79: v = 17'd64332;  7'd80: v = 17'd64540;
      7'd81: v = 17'd64729;  7'd82: v = 17'd64898;  7'd83: v = 17'd65048;
      7'd84: v = 17'd65177;  7'd85: v = 17'd65287;  7'd86: v = 17'd65376;
      7'd87: v = 17'd65446;  7'd88: v = 17'd65496;  7'd89: v = 17'd65526;
      7'd90: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

@@ hw/rtl/point_translate_reflect_rotate_core.sv @@
// Point transform core: translates, reflects or rotates one signed Q15.16 point per
// word. The core never asserts busy, so a word can be started in every clock cycle;
// each result appears on the out_ ports five cycles after its start, for exactly one
// cycle with out_valid high, and must be taken then because the receiver cannot stall
// the core. The latency is set by the pipeline: input register, angle reduction,
// sine/cosine lookup, the four rotation multipliers, and the round-and-clip stage that
// feeds the result register. Results come out in the order the words went in.
module point_translate_reflect_rotate_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_func,
  input  logic signed [ptrr_pkg::COORD_W-1:0] in_x_in,
  input  logic signed [ptrr_pkg::COORD_W-1:0] in_y_in,
  input  logic signed [ptrr_pkg::OFFS_W-1:0]  in_dx,
  input  logic signed [ptrr_pkg::OFFS_W-1:0]  in_dy,
  input  logic                                in_axis,
  input  logic signed [ptrr_pkg::ANGLE_W-1:0] in_angle_deg,
  output logic                                out_valid,
  output logic signed [ptrr_pkg::COORD_W-1:0] out_x_out,
  output logic signed [ptrr_pkg::COORD_W-1:0] out_y_out,
  output logic                                out_saturated
);

  localparam int TW = ptrr_pkg::TRANS_W;

  logic [4:0] vld_r;
  logic [4:0] vld_nxt;

  // Stage 1: input register.
  ptrr_pkg::func_t                     func1_r;
  ptrr_pkg::coord_t                    x1_r;
  ptrr_pkg::coord_t                    y1_r;
  logic signed [ptrr_pkg::OFFS_W-1:0]  dx1_r;
  logic signed [ptrr_pkg::OFFS_W-1:0]  dy1_r;
  logic                                axis1_r;
  logic signed [ptrr_pkg::ANGLE_W-1:0] ang1_r;

  // Stages 2 to 4: coordinates and the non-rotate result travel alongside.
  ptrr_pkg::func_t  func2_r, func3_r, func4_r;
  ptrr_pkg::coord_t x2_r, y2_r, x3_r, y3_r;
  ptrr_pkg::coord_t xp2_r, yp2_r, xp3_r, yp3_r, xp4_r, yp4_r;
  logic             sp2_r, sp3_r, sp4_r;

  ptrr_pkg::coord_t xp_nxt;
  ptrr_pkg::coord_t yp_nxt;
  logic             sp_nxt;

  logic signed [TW-1:0] tx_sum;
  logic signed [TW-1:0] ty_sum;
  logic signed [ptrr_pkg::COORD_W:0] neg_v;
  ptrr_pkg::sat_res_t   sat_a;
  ptrr_pkg::sat_res_t   sat_b;

  ptrr_pkg::trig_t sin3;
  ptrr_pkg::trig_t cos3;

  logic signed [ptrr_pkg::PROD_W-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [ptrr_pkg::SUM_W-1:0]  sum_x;
  logic signed [ptrr_pkg::SUM_W-1:0]  sum_y;
  logic signed [ptrr_pkg::SUM_W-1:0]  rnd_x;
  logic signed [ptrr_pkg::SUM_W-1:0]  rnd_y;
  ptrr_pkg::sat_res_t rot_x;
  ptrr_pkg::sat_res_t rot_y;

  ptrr_pkg::coord_t xo_nxt;
  ptrr_pkg::coord_t yo_nxt;
  logic             so_nxt;
  ptrr_pkg::coord_t xo_r;
  ptrr_pkg::coord_t yo_r;
  logic             so_r;

  assign busy = 1'b0;

  always_comb begin
    vld_nxt = {vld_r[3:0], start};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func1_r <= ptrr_pkg::func_t'(in_func);
    x1_r    <= in_x_in;
    y1_r    <= in_y_in;
    dx1_r   <= in_dx;
    dy1_r   <= in_dy;
    axis1_r <= in_axis;
    ang1_r  <= in_angle_deg;
  end

  // Translate and reflect finish here; rotate overrides them at the last stage.
  always_comb begin
    tx_sum = TW'(x1_r) + (TW'(dx1_r) <<< ptrr_pkg::FRAC_BITS);
    ty_sum = TW'(y1_r) + (TW'(dy1_r) <<< ptrr_pkg::FRAC_BITS);
    neg_v  = (axis1_r == ptrr_pkg::AXIS_X) ? -(ptrr_pkg::COORD_W+1)'(y1_r)
                                            : -(ptrr_pkg::COORD_W+1)'(x1_r);
    sat_a  = ptrr_pkg::sat_coord(ptrr_pkg::SAT_W'(tx_sum));
    sat_b  = ptrr_pkg::sat_coord(ptrr_pkg::SAT_W'(ty_sum));
    xp_nxt = x1_r;
    yp_nxt = y1_r;
    sp_nxt = 1'b0;
    case (func1_r)
      ptrr_pkg::FUNC_TRANSLATE: begin
        xp_nxt = sat_a.value;
        yp_nxt = sat_b.value;
        sp_nxt = sat_a.clipped | sat_b.clipped;
      end
      ptrr_pkg::FUNC_REFLECT: begin
        sat_a = ptrr_pkg::sat_coord(ptrr_pkg::SAT_W'(neg_v));
        if (axis1_r == ptrr_pkg::AXIS_X) begin
          yp_nxt = sat_a.value;
        end else begin
          xp_nxt = sat_a.value;
        end
        sp_nxt = sat_a.clipped;
      end
      default: begin
        sp_nxt = 1'b0;
      end
    endcase
  end

  ptrr_trig u_trig (
    .clk     (clk),
    .angle   (ang1_r),
    .sin_val (sin3),
    .cos_val (cos3)
  );

  always_ff @(posedge clk) begin
    func2_r <= func1_r;
    x2_r    <= x1_r;
    y2_r    <= y1_r;
    xp2_r   <= xp_nxt;
    yp2_r   <= yp_nxt;
    sp2_r   <= sp_nxt;

    func3_r <= func2_r;
    x3_r    <= x2_r;
    y3_r    <= y2_r;
    xp3_r   <= xp2_r;
    yp3_r   <= yp2_r;
    sp3_r   <= sp2_r;

    func4_r <= func3_r;
    xp4_r   <= xp3_r;
    yp4_r   <= yp3_r;
    sp4_r   <= sp3_r;
    pxc_r   <= x3_r * cos3;
    pys_r   <= y3_r * sin3;
    pxs_r   <= x3_r * sin3;
    pyc_r   <= y3_r * cos3;
  end

  // Rounding adds one half and floors, so ties go toward plus infinity.
  always_comb begin
    sum_x = ptrr_pkg::SUM_W'(pxc_r) - ptrr_pkg::SUM_W'(pys_r);
    sum_y = ptrr_pkg::SUM_W'(pxs_r) + ptrr_pkg::SUM_W'(pyc_r);
    rnd_x = (sum_x + (ptrr_pkg::SUM_W'(1) <<< (ptrr_pkg::TRIG_BITS - 1)))
            >>> ptrr_pkg::TRIG_BITS;
    rnd_y = (sum_y + (ptrr_pkg::SUM_W'(1) <<< (ptrr_pkg::TRIG_BITS - 1)))
            >>> ptrr_pkg::TRIG_BITS;
    rot_x = ptrr_pkg::sat_coord(ptrr_pkg::SAT_W'(rnd_x));
    rot_y = ptrr_pkg::sat_coord(ptrr_pkg::SAT_W'(rnd_y));
    if (func4_r == ptrr_pkg::FUNC_ROTATE) begin
      xo_nxt = rot_x.value;
      yo_nxt = rot_y.value;
      so_nxt = rot_x.clipped | rot_y.clipped;
    end else begin
      xo_nxt = xp4_r;
      yo_nxt = yp4_r;
      so_nxt = sp4_r;
    end
  end

  always_ff @(posedge clk) begin
    xo_r <= xo_nxt;
    yo_r <= yo_nxt;
    so_r <= so_nxt;
  end

  assign out_valid     = vld_r[4];
  assign out_x_out     = xo_r;
  assign out_y_out     = yo_r;
  assign out_saturated = so_r;

endmodule

@@ hw/rtl/ptrr_trig.sv @@
module ptrr_trig (
  input  logic                                clk,
  input  logic signed [ptrr_pkg::ANGLE_W-1:0] angle,
  output ptrr_pkg::trig_t                     sin_val,
  output ptrr_pkg::trig_t                     cos_val
);

  // u = angle + 33120 is never negative and is congruent to angle modulo 360.
  localparam int U_W        = 17;
  localparam int RECIP_SH   = 25;
  localparam logic [U_W-1:0] RECIP_360 = U_W'((1 << RECIP_SH) / 360 + 1);
  localparam logic [U_W-1:0] U_OFFSET  = 17'd352;

  logic [U_W-1:0]     u;
  logic [2*U_W-1:0]   prod;
  logic [8:0]         quot;
  logic [U_W-1:0]     rem_full;
  logic [8:0]         rem_nxt;
  logic [8:0]         rem_r;

  logic [1:0]         quad_s;
  logic [1:0]         quad_c;
  logic [6:0]         rr;
  logic [6:0]         idx_s;
  logic [6:0]         idx_c;
  logic [ptrr_pkg::TRIG_BITS:0] mag_s;
  logic [ptrr_pkg::TRIG_BITS:0] mag_c;
  ptrr_pkg::trig_t    sin_nxt;
  ptrr_pkg::trig_t    cos_nxt;
  ptrr_pkg::trig_t    sin_r;
  ptrr_pkg::trig_t    cos_r;

  // Stage one: reduce the angle to 0..359 by a reciprocal multiply.
  always_comb begin
    u        = {1'b0, ~angle[ptrr_pkg::ANGLE_W-1], angle[ptrr_pkg::ANGLE_W-2:0]} + U_OFFSET;
    prod     = u * RECIP_360;
    quot     = prod[RECIP_SH+8:RECIP_SH];
    rem_full = u - U_W'(quot) * 17'd360;
    if (rem_full >= 17'd360) begin
      rem_full = rem_full - 17'd360;
    end
    rem_nxt  = rem_full[8:0];
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
  end

  // Stage two: fold into one quadrant; the cosine sits one quadrant ahead.
  always_comb begin
    if (rem_r < 9'd90) begin
      quad_s = 2'd0;
      rr     = rem_r[6:0];
    end else if (rem_r < 9'd180) begin
      quad_s = 2'd1;
      rr     = 7'(rem_r - 9'd90);
    end else if (rem_r < 9'd270) begin
      quad_s = 2'd2;
      rr     = 7'(rem_r - 9'd180);
    end else begin
      quad_s = 2'd3;
      rr     = 7'(rem_r - 9'd270);
    end
    quad_c  = quad_s + 2'd1;
    idx_s   = quad_s[0] ? 7'd90 - rr : rr;
    idx_c   = quad_c[0] ? 7'd90 - rr : rr;
    mag_s   = ptrr_pkg::sin_quarter(idx_s);
    mag_c   = ptrr_pkg::sin_quarter(idx_c);
    sin_nxt = quad_s[1] ? -$signed({1'b0, mag_s}) : $signed({1'b0, mag_s});
    cos_nxt = quad_c[1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
  end

  always_ff @(posedge clk) begin
    sin_r <= sin_nxt;
    cos_r <= cos_nxt;
  end

  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule
